@@ sv/i2crts_pkg.sv @@
// Shared types, codes and helpers for the I2C register transfer sequencer.
`default_nettype none

package i2crts_pkg;

    // Input command kinds
    localparam logic [1:0] CMD_BEGIN_WRITE = 2'd0;
    localparam logic [1:0] CMD_BEGIN_READ  = 2'd1;
    localparam logic [1:0] CMD_STATUS      = 2'd2;
    localparam logic [1:0] CMD_TICK        = 2'd3;

    // Actions requested from the byte engine
    localparam logic [2:0] ACT_START   = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_ACK_OFF = 3'd2;
    localparam logic [2:0] ACT_STOP    = 3'd3;
    localparam logic [2:0] ACT_DELIVER = 3'd4;
    localparam logic [2:0] ACT_ACK_ON  = 3'd5;
    localparam logic [2:0] ACT_FINISH  = 3'd6;

    // Finish codes
    localparam logic [2:0] RC_OK      = 3'd0;
    localparam logic [2:0] RC_NACK    = 3'd1;
    localparam logic [2:0] RC_ARB     = 3'd2;
    localparam logic [2:0] RC_TIMEOUT = 3'd3;
    localparam logic [2:0] RC_BUS_ERR = 3'd4;

    // Status bit positions
    localparam int ST_START_SENT = 0;
    localparam int ST_ADDR_ACKED = 1;
    localparam int ST_BYTE_DONE  = 2;
    localparam int ST_RX_FULL    = 3;
    localparam int ST_TX_EMPTY   = 4;
    localparam int ST_BUS_ERR    = 5;
    localparam int ST_ARB_LOST   = 6;
    localparam int ST_NACK       = 7;

    localparam logic [7:0] TIMEOUT_RESET = 8'd10;
    localparam int         MAX_RESULTS   = 3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] status;
        logic [7:0] tx_byte;
        logic [8:0] transfer_length;
        logic [7:0] register_address;
        logic [6:0] device_address;
        logic [1:0] command;
    } t_item;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] out_byte;
        logic       took_tx_byte;
        logic [2:0] result_code;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0]                   cnt;
        t_result [MAX_RESULTS-1:0]    res;
    } t_bundle;

    function automatic t_result make_res(
        input logic [2:0] act,
        input logic [7:0] byte_val,
        input logic       took,
        input logic [2:0] code
    );
        t_result r;
        r.action       = act;
        r.out_byte     = byte_val;
        r.took_tx_byte = took;
        r.result_code  = code;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/i2crts_core.sv @@
// Transaction phase machine: one request in, up to three actions out.
`default_nettype none

module i2crts_core
    import i2crts_pkg::*;
#(
    parameter int MAX_TRANSFER = 256
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic    i_step,
    input  wire t_item   i_item,
    output t_bundle      o_bundle
);

    localparam int LenMax = (MAX_TRANSFER < 511) ? MAX_TRANSFER : 511;
    localparam int BlW    = $clog2(LenMax + 1);

    typedef enum logic [3:0] {
        PH_IDLE, PH_SB1, PH_ADDR1, PH_TXE_REG, PH_TXE_DATA,
        PH_BTF_END, PH_BTF_REG, PH_SB2, PH_ADDR2, PH_RX
    } t_phase;

    t_phase          r_phase, n_phase;
    logic            r_is_read, n_is_read;
    logic [6:0]      r_addr, n_addr;
    logic [7:0]      r_ptr, n_ptr;
    logic [BlW-1:0]  r_bl, n_bl;
    logic [7:0]      r_wait, n_wait;
    logic [7:0]      r_timeout;

    logic [7:0]      exp_mask;
    logic [BlW-1:0]  bl_dec;
    logic [BlW-1:0]  len_eff;
    logic [7:0]      wait_inc;
    logic            do_fail;
    logic [2:0]      fail_code;
    t_bundle         bnd;

    always_comb begin
        case (r_phase)
            PH_SB1, PH_SB2:          exp_mask = 8'(1 << ST_START_SENT);
            PH_ADDR1, PH_ADDR2:      exp_mask = 8'(1 << ST_ADDR_ACKED);
            PH_BTF_END, PH_BTF_REG:  exp_mask = 8'(1 << ST_BYTE_DONE);
            PH_RX:                   exp_mask = 8'(1 << ST_RX_FULL);
            PH_TXE_REG, PH_TXE_DATA: exp_mask = 8'(1 << ST_TX_EMPTY);
            default:                 exp_mask = 8'd0;
        endcase
    end

    assign bl_dec   = (r_bl != '0) ? r_bl - BlW'(1) : r_bl;
    assign wait_inc = (r_wait != 8'hFF) ? r_wait + 8'd1 : r_wait;

    always_comb begin
        if (i_item.transfer_length == 9'd0) begin
            len_eff = BlW'(1);
        end else if ({23'd0, i_item.transfer_length} > 32'(MAX_TRANSFER)) begin
            len_eff = BlW'(LenMax);
        end else begin
            len_eff = BlW'(i_item.transfer_length);
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_is_read = r_is_read;
        n_addr    = r_addr;
        n_ptr     = r_ptr;
        n_bl      = r_bl;
        n_wait    = r_wait;
        do_fail   = 1'b0;
        fail_code = RC_OK;
        bnd       = '0;

        if (i_item.command == CMD_BEGIN_WRITE || i_item.command == CMD_BEGIN_READ) begin
            if (r_phase == PH_IDLE) begin
                n_is_read  = (i_item.command == CMD_BEGIN_READ);
                n_addr     = i_item.device_address;
                n_ptr      = i_item.register_address;
                n_bl       = len_eff;
                n_wait     = 8'd0;
                n_phase    = PH_SB1;
                bnd.res[0] = make_res(ACT_START, 8'd0, 1'b0, RC_OK);
                bnd.cnt    = 2'd1;
            end
        end else if (r_phase != PH_IDLE) begin
            if (i_item.command == CMD_STATUS) begin
                if ((i_item.status & exp_mask) != 8'd0) begin
                    // advance on the expected flag
                    n_wait = 8'd0;
                    case (r_phase)
                        PH_SB1: begin
                            bnd.res[0] = make_res(ACT_WRITE, {r_addr, 1'b0}, 1'b0, RC_OK);
                            bnd.cnt    = 2'd1;
                            n_phase    = PH_ADDR1;
                        end
                        PH_ADDR1: begin
                            n_phase = PH_TXE_REG;
                        end
                        PH_TXE_REG: begin
                            bnd.res[0] = make_res(ACT_WRITE, r_ptr, 1'b0, RC_OK);
                            bnd.cnt    = 2'd1;
                            n_phase    = r_is_read ? PH_BTF_REG : PH_TXE_DATA;
                        end
                        PH_TXE_DATA: begin
                            bnd.res[0] = make_res(ACT_WRITE, i_item.tx_byte, 1'b1, RC_OK);
                            bnd.cnt    = 2'd1;
                            n_bl       = bl_dec;
                            if (bl_dec == '0) begin
                                n_phase = PH_BTF_END;
                            end
                        end
                        PH_BTF_END: begin
                            bnd.res[0] = make_res(ACT_STOP, 8'd0, 1'b0, RC_OK);
                            bnd.res[1] = make_res(ACT_FINISH, 8'd0, 1'b0, RC_OK);
                            bnd.cnt    = 2'd2;
                            n_phase    = PH_IDLE;
                        end
                        PH_BTF_REG: begin
                            bnd.res[0] = make_res(ACT_START, 8'd0, 1'b0, RC_OK);
                            bnd.cnt    = 2'd1;
                            n_phase    = PH_SB2;
                        end
                        PH_SB2: begin
                            bnd.res[0] = make_res(ACT_WRITE, {r_addr, 1'b1}, 1'b0, RC_OK);
                            bnd.cnt    = 2'd1;
                            n_phase    = PH_ADDR2;
                        end
                        PH_ADDR2: begin
                            // single byte read: drop ACK and request STOP up front
                            if (r_bl <= BlW'(1)) begin
                                bnd.res[0] = make_res(ACT_ACK_OFF, 8'd0, 1'b0, RC_OK);
                                bnd.res[1] = make_res(ACT_STOP, 8'd0, 1'b0, RC_OK);
                                bnd.cnt    = 2'd2;
                            end
                            n_phase = PH_RX;
                        end
                        PH_RX: begin
                            bnd.res[0] = make_res(ACT_DELIVER, i_item.rx_byte, 1'b0, RC_OK);
                            bnd.cnt    = 2'd1;
                            n_bl       = bl_dec;
                            if (bl_dec == BlW'(1)) begin
                                bnd.res[1] = make_res(ACT_ACK_OFF, 8'd0, 1'b0, RC_OK);
                                bnd.res[2] = make_res(ACT_STOP, 8'd0, 1'b0, RC_OK);
                                bnd.cnt    = 2'd3;
                            end else if (bl_dec == '0) begin
                                bnd.res[1] = make_res(ACT_ACK_ON, 8'd0, 1'b0, RC_OK);
                                bnd.res[2] = make_res(ACT_FINISH, 8'd0, 1'b0, RC_OK);
                                bnd.cnt    = 2'd3;
                                n_phase    = PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end else if (r_wait >= r_timeout) begin
                    do_fail   = 1'b1;
                    fail_code = RC_TIMEOUT;
                end else if (i_item.status[ST_BUS_ERR]) begin
                    do_fail   = 1'b1;
                    fail_code = RC_BUS_ERR;
                end else if (i_item.status[ST_ARB_LOST]) begin
                    do_fail   = 1'b1;
                    fail_code = RC_ARB;
                end else if (i_item.status[ST_NACK]) begin
                    do_fail   = 1'b1;
                    fail_code = RC_NACK;
                end
            end else begin
                n_wait = wait_inc;
                if (wait_inc >= r_timeout) begin
                    do_fail   = 1'b1;
                    fail_code = RC_TIMEOUT;
                end
            end
        end

        if (do_fail) begin
            // no STOP while receiving
            if (r_phase != PH_RX) begin
                bnd.res[0] = make_res(ACT_STOP, 8'd0, 1'b0, RC_OK);
                bnd.res[1] = make_res(ACT_FINISH, 8'd0, 1'b0, fail_code);
                bnd.cnt    = 2'd2;
            end else begin
                bnd.res[0] = make_res(ACT_FINISH, 8'd0, 1'b0, fail_code);
                bnd.cnt    = 2'd1;
            end
            n_phase = PH_IDLE;
            n_wait  = 8'd0;
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            bnd.res[i].last = (bnd.cnt != 2'd0) && (2'(i) == bnd.cnt - 2'd1);
        end
    end

    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_is_read <= 1'b0;
            r_addr    <= 7'd0;
            r_ptr     <= 8'd0;
            r_bl      <= '0;
            r_wait    <= 8'd0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (i_step) begin
                r_phase   <= n_phase;
                r_is_read <= n_is_read;
                r_addr    <= n_addr;
                r_ptr     <= n_ptr;
                r_bl      <= n_bl;
                r_wait    <= n_wait;
            end
        end
    end

`ifndef SYNTH
    a_idle_wait_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_wait == 8'd0)
        else $error("wait counter nonzero while idle");

    a_finish_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && bnd.cnt != 2'd0 && bnd.res[bnd.cnt - 2'd1].action == ACT_FINISH
        |=> r_phase == PH_IDLE)
        else $error("finish reported but transaction still open");

    a_begin_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_IDLE && !i_item.command[1]
        |-> bnd.cnt == 2'd1 && bnd.res[0].action == ACT_START)
        else $error("begin from idle must request exactly one START");
`endif

endmodule

`default_nettype wire

@@ sv/i2crts_outq.sv @@
// Result register that hands a bundle of actions out one action at a time.
`default_nettype none

module i2crts_outq
    import i2crts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_bundle i_bundle,
    output logic         o_free,
    input  wire logic    i_tready,
    output logic         o_tvalid,
    output t_result      o_res
);

    logic    r_valid;
    logic [1:0] r_idx;
    t_bundle r_bundle;
    logic    drain_last;

    assign drain_last = r_valid && i_tready && (r_idx == r_bundle.cnt - 2'd1);
    assign o_free     = !r_valid || drain_last;
    assign o_tvalid   = r_valid;
    assign o_res      = r_bundle.res[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (drain_last) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (r_valid && i_tready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx < r_bundle.cnt)
        else $error("output index past bundle count");

    a_load_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid && r_idx == 2'd0)
        else $error("loaded bundle not presented from first entry");

    a_no_load_over_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free && i_bundle.cnt != 2'd0)
        else $error("bundle loaded over pending results or empty");
`endif

endmodule

`default_nettype wire

@@ sv/i2c_register_transfer_sequencer.sv @@
// Top level of the I2C master register transfer sequencer.
// Requests enter on the s_axis channel: tuser carries the command (begin write,
// begin read, bus status, tick), tdata the begin fields, the tx byte, the status
// flags and the rx byte. Each request yields zero to three actions for the byte
// engine on the m_axis channel: tuser carries the action, tdata the byte, the
// tx-byte-taken flag and the finish code, tlast marks the final action of a request.
// A request is captured in the input register, stepped through the phase machine
// into the result register, and its actions are then offered on m_axis.
// Throughput: one request per cycle while each gives at most one action and
// m_axis_tready stays high; a request with k actions holds the result register
// until all k are taken. Requests that give no action still pass through the step
// stage but load nothing. When m_axis_tready is low a loaded result register holds,
// the step stage waits, and s_axis_tready drops once the input register is full.
// The timeout register is written on the cfg channel, always ready; write it only
// while no transaction is open. Reset (synchronous, active low) returns the phase
// machine to idle, clears both registers' valid flags and sets the timeout to 10.
`default_nettype none

module i2c_register_transfer_sequencer
    import i2crts_pkg::*;
#(
    parameter int MAX_TRANSFER = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // device_address[6:0], register_address[14:7], transfer_length[23:15],
    // tx_byte[31:24], status[39:32], rx_byte[47:40]
    input  wire logic [47:0] s_axis_tdata,
    // command[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_byte[7:0], took_tx_byte[8], result_code[11:9], zero[15:12]
    output logic [15:0]      m_axis_tdata,
    // action[2:0]
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    step;
    logic    out_free;
    t_bundle bundle;
    t_result res;

    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.command          <= s_axis_tuser;
            r_in_item.device_address   <= s_axis_tdata[6:0];
            r_in_item.register_address <= s_axis_tdata[14:7];
            r_in_item.transfer_length  <= s_axis_tdata[23:15];
            r_in_item.tx_byte          <= s_axis_tdata[31:24];
            r_in_item.status           <= s_axis_tdata[39:32];
            r_in_item.rx_byte          <= s_axis_tdata[47:40];
        end
    end

    i2crts_core #(
        .MAX_TRANSFER(MAX_TRANSFER)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_valid),
        .i_cfg_data(i_cfg_data),
        .i_step    (step),
        .i_item    (r_in_item),
        .o_bundle  (bundle)
    );

    i2crts_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && bundle.cnt != 2'd0),
        .i_bundle (bundle),
        .o_free   (out_free),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_res    (res)
    );

    assign m_axis_tdata = {4'd0, res.result_code, res.took_tx_byte, res.out_byte};
    assign m_axis_tuser = res.action;
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
